/* design/tali_pkg.sv */
package tali_pkg;

   localparam int FrameLenDefault = 10;
   localparam int CordicSteps = 16;
   localparam logic [15:0] WarnThresholdReset = 16'd4500;

   localparam logic signed [23:0] QuarterTurn = 24'sd2305168;
   localparam logic signed [15:0] HalfTurnOut = 16'sd18009;

   // signed work width of the cordic datapath: axis sums fit 19 bits,
   // scaled by 2^12 and grown by the cordic gain stays below 2^34
   localparam int DW = 36;
   localparam int AW = 25;

   function automatic logic signed [AW-1:0] atan_entry(input logic [3:0] i);
      logic signed [AW-1:0] r;
      case (i)
         4'd0: r = 25'sd1152584;
         4'd1: r = 25'sd680410;
         4'd2: r = 25'sd359510;
         4'd3: r = 25'sd182493;
         4'd4: r = 25'sd91601;
         4'd5: r = 25'sd45845;
         4'd6: r = 25'sd22928;
         4'd7: r = 25'sd11465;
         4'd8: r = 25'sd5732;
         4'd9: r = 25'sd2866;
         4'd10: r = 25'sd1433;
         4'd11: r = 25'sd717;
         4'd12: r = 25'sd358;
         4'd13: r = 25'sd179;
         4'd14: r = 25'sd90;
         default: r = 25'sd45;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic start;
      logic signed [DW-1:0] den;
      logic signed [DW-1:0] num;
   } cordic_cmd_type;

   typedef struct packed {
      logic done;
      logic signed [15:0] angle;
   } cordic_rsp_type;

endpackage

/* design/tali_cordic.sv */
module tali_cordic (
   input  logic clock,
   input  logic reset,
   input  tali_pkg::cordic_cmd_type cmd,
   output tali_pkg::cordic_rsp_type rsp
);
   localparam int DW = tali_pkg::DW;
   localparam int AW = tali_pkg::AW;

   logic signed [DW-1:0] den_ff, den_in, num_ff, num_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [3:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [15:0] ang_ff, ang_in;
   logic signed [DW-1:0] dsh, nsh;
   logic signed [AW-1:0] rnd;

   always_comb begin
      den_in = den_ff;
      num_in = num_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ang_in = ang_ff;
      dsh = den_ff >>> step_ff;
      nsh = num_ff >>> step_ff;
      rnd = (acc_ff + AW'(128)) >>> 8;
      if (cmd.start) begin
         step_in = '0;
         acc_in = '0;
         den_in = cmd.den;
         num_in = cmd.num;
         busy_in = 1'b1;
         if (cmd.num == '0) begin
            // degenerate vector, angle known at once
            busy_in = 1'b0;
            done_in = 1'b1;
            ang_in = (cmd.den < 0) ? tali_pkg::HalfTurnOut : '0;
         end else if (cmd.den < 0) begin
            if (cmd.num > 0) begin
               den_in = cmd.num;
               num_in = -cmd.den;
               acc_in = AW'(tali_pkg::QuarterTurn);
            end else begin
               den_in = -cmd.num;
               num_in = cmd.den;
               acc_in = -AW'(tali_pkg::QuarterTurn);
            end
         end
      end else if (busy_ff) begin
         if (num_ff > 0) begin
            den_in = den_ff + nsh;
            num_in = num_ff - dsh;
            acc_in = acc_ff + tali_pkg::atan_entry(step_ff);
         end else begin
            den_in = den_ff - nsh;
            num_in = num_ff + dsh;
            acc_in = acc_ff - tali_pkg::atan_entry(step_ff);
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(tali_pkg::CordicSteps - 1)) busy_in = 1'b0;
      end
   end

   // finishing: in the cycle after the last step, round the accumulator
   logic fin_ff, fin_in;
   assign fin_in = busy_ff && !cmd.start && step_ff == 4'(tali_pkg::CordicSteps - 1);

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      num_ff <= num_in;
      acc_ff <= acc_in;
      ang_ff <= fin_ff ? rnd[15:0] : ang_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in | fin_ff;
         fin_ff <= fin_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.angle = ang_ff;
endmodule

/* design/tali_isqrt.sv */
module tali_isqrt (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [38:0] sq,
   output logic done,
   output logic [31:0] root
);
   // bit-serial root of sq * 2^24, one result bit per cycle
   logic [63:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] op_ff, op_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      rem_in = rem_ff;
      root_in = root_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {30'd0, root_ff, 2'b01};
      if (start) begin
         rem_in = '0;
         root_in = '0;
         op_in = {1'b0, sq, 24'd0};
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {30'd0, root_ff, 2'b01};
         rem_in = {rem_ff[61:0], op_ff[63:62]};
         op_in = {op_ff[61:0], 2'b00};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      root_ff <= root_in;
      op_ff <= op_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

/* design/tilt_angle_level_indicator_core.sv */
// sequence: the frame-closing sample runs sums, square root, two cordic runs (roll then pitch),
//   compare and load in that order; a cordic run with a zero numerator finishes at once, and
//   the result waits while the output register is full
// throughput: one transaction per cycle inside a frame, stall held over the frame close
// reset: synchronous active high, clears frame count, zero offsets, last angles,
//   warning and busy state; threshold returns to 4500; sample store is not cleared
module tilt_angle_level_indicator_core #(
   parameter int FRAME_LEN = tali_pkg::FrameLenDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_func,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [15:0] rsp_pitch_delta,
   output logic signed [16:0] rsp_roll_delta,
   output logic rsp_warn_led
);
   localparam int DW = tali_pkg::DW;
   localparam int CW = $clog2(FRAME_LEN);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SUM   = 7'b0000010,
      S_SQRT  = 7'b0000100,
      S_ROLL  = 7'b0001000,
      S_PITCH = 7'b0010000,
      S_OUT   = 7'b0100000,
      S_WAIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] thr_ff;
   logic [CW-1:0] cnt_ff;
   logic signed [15:0] zp_ff, zr_ff, lp_ff, lr_ff;
   logic warn_ff;
   // the five kept samples, one array per axis
   logic signed [15:0] sx_ff [5], sy_ff [5], sz_ff [5];
   logic signed [18:0] x_ff, y_ff, z_ff;
   logic [31:0] rad_ff;
   logic sqrt_start;
   logic sqrt_done;
   logic [31:0] sqrt_root;
   tali_pkg::cordic_cmd_type ccmd;
   tali_pkg::cordic_rsp_type crsp;
   // square root already launched for this frame
   logic launched_ff;
   logic signed [16:0] pc, rc;
   logic accept;
   // output register empty or emptied this cycle
   logic out_free;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid || !rsp_stall;

   // signed divide by 3 truncating toward zero, by reciprocal multiply
   // (43691 = (2^17 + 1) / 3, exact for magnitudes below 2^17)
   function automatic logic signed [17:0] div3(input logic signed [17:0] s);
      logic [16:0] mag;
      logic [32:0] prod;
      logic [15:0] q;
      mag = s[17] ? 17'(-s) : s[16:0];
      prod = 33'(mag) * 33'(17'd43691);
      q = prod[32:17];
      return s[17] ? -$signed({2'b00, q}) : $signed({2'b00, q});
   endfunction

   // truncating three-point average sum for one axis
   function automatic logic signed [18:0] avg_sum(input logic signed [15:0] a0,
      input logic signed [15:0] a1, input logic signed [15:0] a2,
      input logic signed [15:0] a3, input logic signed [15:0] a4);
      logic signed [17:0] s0, s1, s2;
      s0 = 18'(a0) + 18'(a1) + 18'(a2);
      s1 = 18'(a1) + 18'(a2) + 18'(a3);
      s2 = 18'(a2) + 18'(a3) + 18'(a4);
      return 19'(div3(s0)) + 19'(div3(s1)) + 19'(div3(s2));
   endfunction

   logic [38:0] sq;
   logic signed [37:0] yy, zz;
   assign yy = y_ff * y_ff;
   assign zz = z_ff * z_ff;
   assign sq = 39'(yy) + 39'(zz);

   tali_isqrt u_sqrt (.clock, .reset, .start(sqrt_start), .sq,
                      .done(sqrt_done), .root(sqrt_root));
   tali_cordic u_cordic (.clock, .reset, .cmd(ccmd), .rsp(crsp));

   always_comb begin
      state_in = state_ff;
      sqrt_start = 1'b0;
      ccmd.start = 1'b0;
      ccmd.den = DW'(z_ff) <<< 12;
      ccmd.num = -(DW'(y_ff) <<< 12);
      unique case (state_ff)
         S_IDLE: if (accept && !req_func && cnt_ff == CW'(FRAME_LEN - 1)) state_in = S_SUM;
         S_SUM: state_in = S_SQRT;
         S_SQRT: begin
            // sums settled in the previous cycle, launch the root once
            if (!launched_ff) sqrt_start = 1'b1;
            if (sqrt_done) begin
               ccmd.start = 1'b1;
               state_in = S_ROLL;
            end
         end
         S_ROLL: if (crsp.done) begin
            ccmd.start = 1'b1;
            ccmd.den = DW'({1'b0, rad_ff});
            ccmd.num = DW'(x_ff) <<< 12;
            state_in = S_PITCH;
         end
         S_PITCH: if (crsp.done) state_in = S_OUT;
         S_OUT: state_in = S_WAIT;
         // hold until the output register can take the result
         S_WAIT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign pc = 17'(lp_ff) - 17'(zp_ff);
   assign rc = 17'(lr_ff) - 17'(zr_ff);

   always_ff @(posedge clock) begin
      if (accept && !req_func && cnt_ff >= CW'(1) && cnt_ff <= CW'(5)) begin
         sx_ff[3'(cnt_ff - CW'(1))] <= req_accel_x;
         sy_ff[3'(cnt_ff - CW'(1))] <= req_accel_y;
         sz_ff[3'(cnt_ff - CW'(1))] <= req_accel_z;
      end
      if (state_ff == S_SUM) begin
         x_ff <= avg_sum(sx_ff[0], sx_ff[1], sx_ff[2], sx_ff[3], sx_ff[4]);
         y_ff <= avg_sum(sy_ff[0], sy_ff[1], sy_ff[2], sy_ff[3], sy_ff[4]);
         z_ff <= avg_sum(sz_ff[0], sz_ff[1], sz_ff[2], sz_ff[3], sz_ff[4]);
      end
      if (sqrt_done) rad_ff <= sqrt_root;
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= tali_pkg::WarnThresholdReset;
         cnt_ff <= '0;
         zp_ff <= '0;
         zr_ff <= '0;
         lp_ff <= '0;
         lr_ff <= '0;
         warn_ff <= 1'b0;
         rsp_valid <= 1'b0;
         launched_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launched_ff <= (state_ff == S_SQRT);
         if (csr_write_enable) thr_ff <= csr_write_data;
         if (accept) begin
            if (req_func) begin
               // calibrate: last angles become the new zero, warning cleared
               zp_ff <= lp_ff;
               zr_ff <= lr_ff;
               warn_ff <= 1'b0;
            end else if (cnt_ff == CW'(FRAME_LEN - 1)) begin
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
         if (state_ff == S_ROLL && crsp.done) lr_ff <= crsp.angle;
         if (state_ff == S_PITCH && crsp.done) lp_ff <= crsp.angle;
         if (state_ff == S_OUT) begin
            if (pc > $signed({1'b0, thr_ff}) || rc > $signed({1'b0, thr_ff}))
               warn_ff <= 1'b1;
         end
         if (state_ff == S_WAIT && out_free) begin
            rsp_valid <= 1'b1;
            rsp_pitch_delta <= pc[15:0];
            rsp_roll_delta <= rc;
            rsp_warn_led <= warn_ff;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end
endmodule

/* test/tilt_angle_level_indicator_core_tb.sv */
module tilt_angle_level_indicator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FrameLen = tali_pkg::FrameLenDefault;
   localparam int CycleLimit = 1500000;
   localparam int Quarter = 2305168;
   localparam int HalfAngle = 18009;

   typedef enum logic {FUNC_SAMPLE = 1'b0, FUNC_CALIBRATE = 1'b1} func_kind_type;

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [16:0] roll;
      logic warn;
   } tilt_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = FUNC_SAMPLE;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_pitch_delta;
   logic signed [16:0] rsp_roll_delta;
   logic rsp_warn_led;

   tilt_angle_level_indicator_core DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_accel_x(req_accel_x),
      .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pitch_delta(rsp_pitch_delta),
      .rsp_roll_delta(rsp_roll_delta),
      .rsp_warn_led(rsp_warn_led)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the block's state
   logic [15:0] tilt_threshold = 16'd4500;
   logic signed [15:0] held_samples [15];
   int frame_pos = 0;
   logic signed [15:0] zero_p = 0, zero_r = 0, last_p = 0, last_r = 0;
   logic warn_state = 1'b0;
   tilt_result_type angle_queue [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int error_count = 0;
   int cycle_count = 0;

   const int atan_steps [16] = '{1152584, 680410, 359510, 182493, 91601, 45845, 22928,
      11465, 5732, 2866, 1433, 717, 358, 179, 90, 45};

   // arithmetic right shift, floor division by 2^s
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_root(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(root);
   endfunction

   // cordic vectoring atan2 in hundredths
   function automatic int tilt_atan2(longint den, longint num);
      longint acc = 0;
      longint t, nd, nn;
      if (num == 0) return (den < 0) ? HalfAngle : 0;
      if (den < 0) begin
         if (num > 0) begin
            t = den; den = num; num = -t; acc = Quarter;
         end else begin
            t = den; den = -num; num = t; acc = -Quarter;
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (num > 0) begin
            nd = den + shr_floor(num, i);
            nn = num - shr_floor(den, i);
            acc += atan_steps[i];
         end else begin
            nd = den - shr_floor(num, i);
            nn = num + shr_floor(den, i);
            acc -= atan_steps[i];
         end
         den = nd;
         num = nn;
      end
      return int'(shr_floor(acc + 128, 8));
   endfunction

   // three truncated three-point averages summed
   function automatic longint smoothed_axis(int axis);
      longint total = 0;
      int s;
      for (int j = 0; j < 3; j++) begin
         s = int'(held_samples[j*3+axis]) + int'(held_samples[(j+1)*3+axis])
            + int'(held_samples[(j+2)*3+axis]);
         total += s / 3;
      end
      return total;
   endfunction

   task automatic predict_tilt(func_kind_type f, logic signed [15:0] ax,
                               logic signed [15:0] ay, logic signed [15:0] az);
      longint x, y, z, rad;
      int pc, rc;
      tilt_result_type r;
      if (f == FUNC_CALIBRATE) begin
         zero_r = last_r;
         zero_p = last_p;
         warn_state = 1'b0;
         return;
      end
      if (frame_pos >= 1 && frame_pos <= 5) begin
         held_samples[(frame_pos-1)*3] = ax;
         held_samples[(frame_pos-1)*3+1] = ay;
         held_samples[(frame_pos-1)*3+2] = az;
      end
      if (frame_pos < FrameLen - 1) begin
         frame_pos++;
         return;
      end
      frame_pos = 0;
      x = smoothed_axis(0);
      y = smoothed_axis(1);
      z = smoothed_axis(2);
      rad = int_root(longint'(y*y + z*z) << 24);
      last_r = 16'(tilt_atan2(z*4096, -y*4096));
      last_p = 16'(tilt_atan2(rad, x*4096));
      pc = int'(last_p) - int'(zero_p);
      rc = int'(last_r) - int'(zero_r);
      if (pc > int'(tilt_threshold) || rc > int'(tilt_threshold)) warn_state = 1'b1;
      r.pitch = 16'(pc);
      r.roll = 17'(rc);
      r.warn = warn_state;
      angle_queue.push_back(r);
   endtask

   // send one transaction, predict on acceptance; valid stays up for a following item
   task automatic send_item(func_kind_type f, logic signed [15:0] ax,
                            logic signed [15:0] ay, logic signed [15:0] az);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      do @(posedge clock); while (req_stall);
      predict_tilt(f, ax, ay, az);
      @(negedge clock);
   endtask

   task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      send_item(FUNC_SAMPLE, ax, ay, az);
   endtask

   // random level-ish frame: mostly coherent vectors, some full-range noise
   task automatic send_frame(int spread);
      logic signed [15:0] bx, by, bz;
      bx = 16'($urandom);
      by = 16'($urandom);
      bz = 16'($urandom);
      if ($urandom_range(3) != 0) begin
         bx = bx >>> $urandom_range(15);
         by = by >>> $urandom_range(15);
         bz = bz >>> $urandom_range(15);
      end
      for (int k = 0; k < FrameLen; k++) begin
         if ($urandom_range(19) == 0) send_item(FUNC_CALIBRATE, 16'($urandom),
            16'($urandom), 16'($urandom));
         send_sample(bx + 16'($signed($urandom_range(2*spread)) - spread),
                     by + 16'($signed($urandom_range(2*spread)) - spread),
                     bz + 16'($signed($urandom_range(2*spread)) - spread));
      end
   endtask

   // stop offering items, then wait for every expected result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (angle_queue.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_threshold(logic [15:0] v);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      tilt_threshold = v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // result channel: random stall, optional long hold-off
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      tilt_result_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angle_queue.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            e = angle_queue.pop_front();
            if (rsp_pitch_delta !== e.pitch) begin
               $error("pitch_delta expected %0d actual %0d", e.pitch, rsp_pitch_delta);
               error_count++;
            end
            if (rsp_roll_delta !== e.roll) begin
               $error("roll_delta expected %0d actual %0d", e.roll, rsp_roll_delta);
               error_count++;
            end
            if (rsp_warn_led !== e.warn) begin
               $error("warn_led expected %0d actual %0d", e.warn, rsp_warn_led);
               error_count++;
            end
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("tilt_angle_level_indicator_core_tb: done, errors");
         $finish;
      end
   end

   // directed: extremes, zero numerator, negative denominator, calibrate
   task automatic test_directed();
      send_item(FUNC_CALIBRATE, 16'sh7fff, 16'sh8000, 16'sh7fff);
      for (int k = 0; k < FrameLen; k++)
         send_sample(16'sh7fff, 16'sh8000, 16'sh8000);
      for (int k = 0; k < FrameLen; k++)
         send_sample(16'sh8000, 16'sh0000, -16'sd1000);
      send_item(FUNC_CALIBRATE, 16'sh0000, 16'sh0000, 16'sh0000);
      for (int k = 0; k < FrameLen; k++) send_sample(16'sh0000, 16'sh0000, 16'sh0000);
   endtask

   // every threshold extreme exercised
   task automatic test_thresholds();
      write_threshold(16'd0);
      repeat (3) send_frame(20);
      write_threshold(16'hffff);
      repeat (3) send_frame(20);
      write_threshold(16'd36100);
      repeat (3) send_frame(200);
      write_threshold(16'd4500);
   endtask

   task automatic test_random(int frames);
      for (int f = 0; f < frames; f++) send_frame($urandom_range(1) ? 8 : 3000);
   endtask

   // long receiver hold-off while frames keep coming
   task automatic test_backpressure();
      hold_off_cycles = 600;
      repeat (3) send_frame(10);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_thresholds();
      send_idle_pct = 9;
      recv_idle_pct = 68;
      test_random(25);
      send_idle_pct = 68;
      recv_idle_pct = 9;
      test_random(25);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(25);
      test_backpressure();
      drain_results();
      if (error_count == 0) begin
         $display("tilt_angle_level_indicator_core_tb: done, clean");
      end else begin
         $display("tilt_angle_level_indicator_core_tb: done, errors");
      end
      $finish;
   end
endmodule
